### hdl/c2d_pkg.sv
package c2d_pkg;

  // Default build sizes
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // Register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SIZE_W     = 11;
  localparam int SHIFT_W    = 3;
  localparam int COEF_W     = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_ROW0  = 3'd2,
    CFG_KERNEL_ROW1  = 3'd3,
    CFG_KERNEL_ROW2  = 3'd4,
    CFG_OUTPUT_SHIFT = 3'd5
  } cfg_idx_t;

  localparam logic [SIZE_W-1:0]  RST_SIZE  = 11'd1024;
  localparam logic [SHIFT_W-1:0] RST_SHIFT = 3'd4;

  // Item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Result range
  localparam int RES_W   = 20;
  localparam int RES_MAX = 524287;
  localparam int RES_MIN = -524288;

  // Border flags for the output centre
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

### hdl/conv2d_3x3_zero_pad_top.sv
// Channel  Group    Handshake        Payload
// input    in_*     tvalid/tready    tdata: pixel_value; tuser: opcode
// result   out_*    tvalid/tready    tdata: result_value; tlast: last_of_frame
// config   cfg_*    cfg_we           cfg_addr index, cfg_wdata value
//
// One item per clock unless the result side stalls; a result is offered after its item
// passes the product register and the sum register; the line stores are read ahead.
// Results trail input by one row plus one pixel; width+1 drain items end a frame.
// Reset is synchronous on rst_n; the line stores are not cleared.
// A stalled result stalls the whole pipe and in_tready drops in the same cycle.
module conv2d_3x3_zero_pad_top
  import c2d_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     in_tdata,   // pixel_value
  input  logic                                in_tuser,   // opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // result_value
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HHW = $clog2(MAX_HEIGHT + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 2);
  localparam int CWW = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int CHW = (HHW > SIZE_W) ? HHW : SIZE_W;

  // Configuration registers
  logic [SIZE_W-1:0]     width_r, height_r;
  logic [CFG_DATA_W-1:0] krow_r [3];
  logic [SHIFT_W-1:0]    shift_r;
  logic                  restart;

  assign restart = cfg_we && ((cfg_idx_t'(cfg_addr) == CFG_IMAGE_WIDTH) ||
                              (cfg_idx_t'(cfg_addr) == CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SIZE;
      height_r <= RST_SIZE;
      for (int i = 0; i < 3; i++) krow_r[i] <= '0;
      shift_r  <= RST_SHIFT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_IMAGE_WIDTH:  width_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_KERNEL_ROW0:  krow_r[0] <= cfg_wdata;
        CFG_KERNEL_ROW1:  krow_r[1] <= cfg_wdata;
        CFG_KERNEL_ROW2:  krow_r[2] <= cfg_wdata;
        CFG_OUTPUT_SHIFT: shift_r   <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to 1..max
  logic [CWW-1:0] wext;
  logic [CHW-1:0] hext;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;

  always_comb begin
    wext = CWW'(width_r);
    hext = CHW'(height_r);
    if (wext == '0) begin
      eff_w = WW'(1);
    end else if (wext > CWW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = wext[WW-1:0];
    end
    if (hext == '0) begin
      eff_h = HW'(1);
    end else if (hext > CHW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(hext[HHW-1:0]);
    end
  end

  // Handshake
  logic en, acc;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // Stream position and output position
  logic [WW-1:0] col_r, col_nxt, ocol_r, ocol_nxt, col_inc;
  logic [HW-1:0] row_r, row_nxt, orow_r, orow_nxt;
  logic          emit, last, col_wrap;
  logic [PIXEL_BITS-1:0] pix_v;

  assign col_inc  = col_r + WW'(1);
  assign col_wrap = col_inc >= eff_w;
  assign emit     = (row_r >= HW'(2)) || ((row_r == HW'(1)) && (col_r != '0));
  assign last     = (ocol_r == eff_w - WW'(1)) && (orow_r == eff_h - HW'(1));
  assign pix_v    = ((in_tuser == OP_PIXEL) && (row_r < eff_h)) ?
                    in_tdata[PIXEL_BITS-1:0] : '0;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (acc) begin
      if (emit && last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end else begin
        col_nxt = col_wrap ? '0 : col_inc;
        row_nxt = col_wrap ? row_r + HW'(1) : row_r;
        if (emit) begin
          if (ocol_r + WW'(1) >= eff_w) begin
            ocol_nxt = '0;
            orow_nxt = orow_r + HW'(1);
          end else begin
            ocol_nxt = ocol_r + WW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // Line stores, read ahead at the next column
  logic [PIXEL_BITS-1:0] up_rd, lo_rd;
  logic [AW-1:0]         raddr;

  assign raddr = col_nxt[AW-1:0];

  c2d_line_store #(.ADDR_W(AW), .DATA_W(PIXEL_BITS)) u_store_upper (
    .clk   (clk),
    .we    (acc),
    .waddr (col_r[AW-1:0]),
    .wdata (lo_rd),
    .raddr (raddr),
    .rdata (up_rd)
  );

  c2d_line_store #(.ADDR_W(AW), .DATA_W(PIXEL_BITS)) u_store_lower (
    .clk   (clk),
    .we    (acc),
    .waddr (col_r[AW-1:0]),
    .wdata (pix_v),
    .raddr (raddr),
    .rdata (lo_rd)
  );

  // Window: two column cells fed by the incoming column
  logic [PIXEL_BITS-1:0] new_col [3];
  logic [PIXEL_BITS-1:0] win_l   [3];
  logic [PIXEL_BITS-1:0] win_c   [3];

  assign new_col[0] = up_rd;
  assign new_col[1] = lo_rd;
  assign new_col[2] = pix_v;

  c2d_win_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_l (
    .clk (clk), .rst_n (rst_n), .clr (restart), .en (acc),
    .d (win_c), .q (win_l)
  );

  c2d_win_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_c (
    .clk (clk), .rst_n (rst_n), .clr (restart), .en (acc),
    .d (new_col), .q (win_c)
  );

  // Taps; at column 0 the centre is the last pixel of the previous row
  logic [PIXEL_BITS-1:0] tap [9];
  border_t               border;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tap[i*3+0] = win_l[i];
      tap[i*3+1] = win_c[i];
      tap[i*3+2] = (col_r == '0) ? '0 : new_col[i];
    end
    border.top    = (orow_r == '0);
    border.bottom = (orow_r >= eff_h - HW'(1));
    border.left   = (ocol_r == '0);
    border.right  = (ocol_r >= eff_w - WW'(1));
  end

  logic [RES_W-1:0] res_value;

  c2d_mac #(.PIXEL_BITS(PIXEL_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (acc && emit),
    .in_last   (last),
    .border    (border),
    .tap       (tap),
    .krow      (krow_r),
    .shift     (shift_r),
    .out_vld   (out_tvalid),
    .out_last  (out_tlast),
    .out_value (res_value)
  );

  assign out_tdata = {{(24-RES_W){1'b0}}, res_value};

  // Checks
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < eff_w)
    else $error("column beyond row width");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit && last && !restart) |=> (col_r == '0) && (row_r == '0) && (ocol_r == '0))
    else $error("position not cleared after last result");

  a_emit_row: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (row_r != '0))
    else $error("result in first row");

endmodule

### hdl/c2d_line_store.sv
module c2d_line_store
  import c2d_pkg::*;
#(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, new data passed through on a same-address write
  always_ff @(posedge clk) begin
    if (we && (raddr == waddr)) begin
      rd_r <= wdata;
    end else begin
      rd_r <= mem[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

### hdl/c2d_win_cell.sv
module c2d_win_cell
  import c2d_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  en,
  input  logic [PIXEL_BITS-1:0] d [3],
  output logic [PIXEL_BITS-1:0] q [3]
);

  logic [PIXEL_BITS-1:0] col_r   [3];
  logic [PIXEL_BITS-1:0] col_nxt [3];

  // One window column: top, middle, bottom pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (clr) begin
        col_nxt[i] = '0;
      end else if (en) begin
        col_nxt[i] = d[i];
      end else begin
        col_nxt[i] = col_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) col_r[i] <= '0;
    end else begin
      for (int i = 0; i < 3; i++) col_r[i] <= col_nxt[i];
    end
  end

  assign q = col_r;

endmodule

### hdl/c2d_mac.sv
module c2d_mac
  import c2d_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic                  in_last,
  input  border_t               border,
  input  logic [PIXEL_BITS-1:0] tap [9],
  input  logic [CFG_DATA_W-1:0] krow [3],
  input  logic [SHIFT_W-1:0]    shift,
  output logic                  out_vld,
  output logic                  out_last,
  output logic [RES_W-1:0]      out_value
);

  localparam int PW = PIXEL_BITS + COEF_W + 1;
  localparam int SW = (PIXEL_BITS + 13 > RES_W + 1) ? PIXEL_BITS + 13 : RES_W + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(RES_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(RES_MIN);

  logic signed [PW-1:0] prod_r   [9];
  logic signed [PW-1:0] prod_nxt [9];
  logic                 va_r, last_a_r;
  logic                 vo_r, last_o_r;
  logic [RES_W-1:0]     val_r;
  logic signed [SW-1:0] sum, shifted;
  logic [RES_W-1:0]     val_nxt;
  logic                 keep;
  logic signed [COEF_W-1:0] coef;

  // Stage A: nine products, border taps forced to zero
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      coef = krow[k/3][(k%3)*COEF_W +: COEF_W];
      keep = 1'b1;
      if ((k / 3 == 0) && border.top)    keep = 1'b0;
      if ((k / 3 == 2) && border.bottom) keep = 1'b0;
      if ((k % 3 == 0) && border.left)   keep = 1'b0;
      if ((k % 3 == 2) && border.right)  keep = 1'b0;
      prod_nxt[k] = keep ? PW'($signed({1'b0, tap[k]}) * coef) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) prod_r[k] <= prod_nxt[k];
      last_a_r <= in_last;
    end
  end

  // Stage B: sum, arithmetic shift, saturate
  always_comb begin
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      sum = sum + SW'(prod_r[k]);
    end
    shifted = sum >>> shift;
    if (shifted > SAT_HI) begin
      val_nxt = SAT_HI[RES_W-1:0];
    end else if (shifted < SAT_LO) begin
      val_nxt = SAT_LO[RES_W-1:0];
    end else begin
      val_nxt = shifted[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r    <= val_nxt;
      last_o_r <= last_a_r;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vo_r <= va_r;
    end
  end

  assign out_vld   = vo_r;
  assign out_last  = last_o_r;
  assign out_value = val_r;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import c2d_pkg::*;

  localparam int PIX_W      = 8;
  localparam int LINE_MAX   = DEF_MAX_WIDTH;
  localparam int ROWS_MAX   = DEF_MAX_HEIGHT;
  localparam int STALL_LIM  = 5000;
  localparam int SETTLE_CYC = 12;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX7 = 3'd7;

  typedef struct {
    logic             op;
    logic [PIX_W-1:0] pix;
  } pixel_item_t;

  typedef struct {
    logic [RES_W-1:0] value;
    logic             last;
  } conv_out_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [23:0]            out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  conv2d_3x3_zero_pad_top dut (.*);

  // Shadow copy of the block's registers and pipeline state
  logic [SIZE_W-1:0]     sh_width, sh_height;
  logic [CFG_DATA_W-1:0] sh_krow [3];
  logic [SHIFT_W-1:0]    sh_shift;
  logic [PIX_W-1:0]      upper_line [LINE_MAX];
  logic [PIX_W-1:0]      lower_line [LINE_MAX];
  logic [PIX_W-1:0]      win [9];
  int unsigned           pos_col, pos_row, out_count;

  pixel_item_t pending_items[$];
  conv_out_t   expected_pixels[$];

  int  failures, cycle_no, quiet_cycles, items_taken, results_seen, frames_seen;
  int  phases_run, recv_hold;
  bit  in_taken, big_stall_done;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] r, int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic void restart_frame();
    pos_col = 0; pos_row = 0; out_count = 0;
    foreach (win[k]) win[k] = '0;
  endfunction

  function automatic void shadow_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        sh_width = val[SIZE_W-1:0]; restart_frame();
      end
      CFG_IMAGE_HEIGHT: begin
        sh_height = val[SIZE_W-1:0]; restart_frame();
      end
      CFG_KERNEL_ROW0: sh_krow[0] = val;
      CFG_KERNEL_ROW1: sh_krow[1] = val;
      CFG_KERNEL_ROW2: sh_krow[2] = val;
      CFG_OUTPUT_SHIFT: sh_shift = val[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the window by one item and queue the convolution output it yields
  function automatic void convolve_item(logic op, logic [PIX_W-1:0] pix);
    int unsigned w, h, col, row, orow, ocol;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] tap [3][3];
    longint sum, r;
    bit emit, last;
    conv_out_t res;
    w = eff_size(sh_width, LINE_MAX);
    h = eff_size(sh_height, ROWS_MAX);
    col = pos_col; row = pos_row;
    if (col >= w) col = 0;
    v = (op == OP_PIXEL && row < h) ? pix : '0;
    emit = (longint'(row) * w + col) >= w + 1;
    // column 0: centre is end of previous row, take window before the shift
    for (int i = 0; i < 3; i++) begin
      tap[i][0] = win[i*3+1]; tap[i][1] = win[i*3+2]; tap[i][2] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1]; win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_line[col];
    win[5] = lower_line[col];
    win[8] = v;
    upper_line[col] = lower_line[col];
    lower_line[col] = v;
    if (col != 0)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) tap[i][j] = win[i*3+j];
    col++;
    if (col >= w) begin
      col = 0; row++;
    end
    pos_col = col; pos_row = row;
    if (!emit) return;
    orow = out_count / w;
    ocol = out_count % w;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (i == 0 && orow == 0) continue;
      if (i == 2 && orow + 1 >= h) continue;
      for (int j = 0; j < 3; j++) begin
        if (j == 0 && ocol == 0) continue;
        if (j == 2 && ocol + 1 >= w) continue;
        sum += longint'(tap[i][j]) * longint'($signed(sh_krow[i][8*j +: 8]));
      end
    end
    r = sum >>> sh_shift;
    if (r > RES_MAX) r = RES_MAX;
    if (r < RES_MIN) r = RES_MIN;
    last = (longint'(out_count) + 1) >= longint'(w) * h;
    res.value = r[RES_W-1:0];
    res.last  = last;
    expected_pixels.push_back(res);
    if (last) begin
      pos_col = 0; pos_row = 0; out_count = 0;
    end else begin
      out_count = (out_count + 1) & 20'hFFFFF;
    end
  endfunction

  function automatic bit idle_now();
    if (cycle_no >= 800 && cycle_no < 1200) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  // Input driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_items.size() > 0 && !idle_now()) begin
        pixel_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= it.op;
        in_tdata  <= it.pix;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off once the stream is busy
  always @(negedge clk) begin
    if (!big_stall_done && items_taken >= 40) begin
      big_stall_done = 1'b1;
      recv_hold = 400;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !idle_now();
    end
  end

  // Sample both channels, predict and check
  always @(posedge clk) begin
    bit fired;
    conv_out_t e;
    fired = 1'b0;
    cycle_no++;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        fired = 1'b1;
        items_taken++;
        convolve_item(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        fired = 1'b1;
        results_seen++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: result_value actual %h", out_tdata);
          failures++;
        end else begin
          e = expected_pixels.pop_front();
          if (out_tdata !== {4'b0, e.value}) begin
            $error("result_value: expected %h actual %h", {4'b0, e.value}, out_tdata);
            failures++;
          end
          if (out_tlast !== e.last) begin
            $error("last_of_frame: expected %b actual %b", e.last, out_tlast);
            failures++;
          end
          if (e.last) frames_seen++;
        end
      end
    end
    // watchdog
    quiet_cycles = fired ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_pixels.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_frame(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                           logic [CFG_DATA_W-1:0] k0, logic [CFG_DATA_W-1:0] k1,
                           logic [CFG_DATA_W-1:0] k2, logic [SHIFT_W-1:0] s);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_KERNEL_ROW0, k0);
    write_reg(CFG_KERNEL_ROW1, k1);
    write_reg(CFG_KERNEL_ROW2, k2);
    write_reg(CFG_OUTPUT_SHIFT, CFG_DATA_W'(s));
    phases_run++;
  endtask

  function automatic void push_item(logic op, logic [PIX_W-1:0] pix);
    pixel_item_t it;
    it.op = op; it.pix = pix;
    pending_items.push_back(it);
  endfunction

  // One frame: pixels with occasional in-frame drains, then the flush
  // (flush items sometimes sent as pixels past the last row). cut>0 stops early.
  function automatic int queue_frame(int drain_pct, int cut);
    int unsigned w, h, n;
    n = 0;
    w = eff_size(sh_width, LINE_MAX);
    h = eff_size(sh_height, ROWS_MAX);
    for (int unsigned k = 0; k < w * h + w + 1; k++) begin
      if (cut > 0 && n >= cut) break;
      if (k < w * h)
        push_item(($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_PIXEL,
                  PIX_W'($urandom_range(255)));
      else
        push_item(($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN,
                  PIX_W'($urandom_range(255)));
      n++;
    end
    return n;
  endfunction

  initial begin
    int rand_items, n;
    logic [SIZE_W-1:0] w, h;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = OP_PIXEL;
    out_tready = 1'b0; cfg_we = 1'b0; cfg_addr = CFG_IMAGE_WIDTH; cfg_wdata = '0;
    failures = 0; cycle_no = 0; quiet_cycles = 0; items_taken = 0; results_seen = 0;
    frames_seen = 0; phases_run = 0; recv_hold = 0; in_taken = 0; big_stall_done = 0;
    sh_width = RST_SIZE; sh_height = RST_SIZE; sh_shift = RST_SHIFT;
    foreach (sh_krow[k]) sh_krow[k] = '0;
    foreach (upper_line[k]) begin
      upper_line[k] = '0; lower_line[k] = '0;
    end
    restart_frame();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: 3x3 with extreme coefficients and pixels, drain inside frame
    set_frame(11'd3, 11'd3, 24'h7F807F, 24'h807F80, 24'hFF01FF, 3'd0);
    write_reg(CFG_SPARE_IDX6, 24'hFFFFFF);
    write_reg(CFG_SPARE_IDX7, 24'h000001);
    push_item(OP_PIXEL, 8'hFF); push_item(OP_PIXEL, 8'h00); push_item(OP_PIXEL, 8'hFF);
    push_item(OP_DRAIN, 8'hAA); push_item(OP_PIXEL, 8'hFF); push_item(OP_PIXEL, 8'h55);
    push_item(OP_PIXEL, 8'hFF); push_item(OP_PIXEL, 8'hFF); push_item(OP_PIXEL, 8'h01);
    push_item(OP_PIXEL, 8'hFF); push_item(OP_DRAIN, 8'h00);
    push_item(OP_DRAIN, 8'hFF); push_item(OP_PIXEL, 8'h80);
    // size 0 acts as 1, largest shift
    set_frame(11'd0, 11'd0, 24'hFFFFFF, 24'h7F7F7F, 24'h808080, 3'd7);
    push_item(OP_PIXEL, 8'hFF); push_item(OP_DRAIN, 8'h00); push_item(OP_PIXEL, 8'h7F);
    push_item(OP_PIXEL, 8'h12); push_item(OP_DRAIN, 8'h00); push_item(OP_DRAIN, 8'h00);

    // Clamped sizes, cut short: three columns of many rows, then an over-wide row
    set_frame(11'd3, 11'd2047, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
              CFG_DATA_W'($urandom), 3'd3);
    void'(queue_frame(5, 90));
    set_frame(11'd2047, 11'd1, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
              CFG_DATA_W'($urandom), 3'd4);
    void'(queue_frame(5, 40));

    // Random phases of small frames; some cut short, some back to back
    rand_items = 0;
    while (rand_items < 480) begin
      w = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(9, 40)) :
                                     SIZE_W'($urandom_range(1, 8));
      h = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(1, 2)) :
                                     SIZE_W'($urandom_range(1, 6));
      if (w > 8) h = SIZE_W'($urandom_range(1, 2));
      set_frame(w, h, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom), SHIFT_W'($urandom_range(7)));
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        n = queue_frame($urandom_range(15),
                        ($urandom_range(7) == 0) ? $urandom_range(1, 20) : 0);
        rand_items += n;
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Covered %0d items, %0d results, %0d frames over %0d register settings,",
             items_taken, results_seen, frames_seen, phases_run);
    $display("with drains in frame, pixels past the last row, cut frames and stalls.");
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/c2d_pkg.sv
hdl/c2d_line_store.sv
hdl/c2d_win_cell.sv
hdl/c2d_mac.sv
hdl/conv2d_3x3_zero_pad_top.sv
sim/testbench.sv
